### rtl/vre_pkg.sv
// ----------------------------------------------------------------------------
// vre_pkg
// Shared widths, register codes and structs of the route evaluator.
// ----------------------------------------------------------------------------
package vre_pkg;

	localparam int TIME_W   = 24;
	localparam int DEMAND_W = 16;
	localparam int LOAD_W   = 24;
	localparam int ACC_W    = 32;
	localparam int CFG_W    = 16;
	localparam int OBJ_W    = 48;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(200);
	localparam logic [CFG_W-1:0] WEIGHT_RESET   = CFG_W'(256);

	typedef enum logic [1:0] {
		REG_VEHICLE_CAPACITY = 2'd0,
		REG_CAPACITY_WEIGHT  = 2'd1,
		REG_DURATION_WEIGHT  = 2'd2,
		REG_WINDOW_WEIGHT    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] vehicle_capacity;
		logic [CFG_W-1:0] capacity_weight;
		logic [CFG_W-1:0] duration_weight;
		logic [CFG_W-1:0] window_weight;
	} cfg_t;

	typedef struct packed {
		logic [ACC_W-1:0]  distance;
		logic [LOAD_W-1:0] load;
		logic [ACC_W-1:0]  completion;
		logic [ACC_W-1:0]  lateness;
	} totals_t;

	typedef struct packed {
		totals_t           tot;
		logic [TIME_W-1:0] due;
	} route_snap_t;

endpackage

### rtl/vre_visit_if.sv
// ----------------------------------------------------------------------------
// vre_visit_if
// Visit channel: one route stop per transfer.
// ----------------------------------------------------------------------------
interface vre_visit_if import vre_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                first_in_route;
	logic                last_in_route;
	logic [TIME_W-1:0]   travel_time;
	logic [DEMAND_W-1:0] demand;
	logic [TIME_W-1:0]   ready_time;
	logic [TIME_W-1:0]   due_time;
	logic [TIME_W-1:0]   service_time;

	modport source (
		output valid, first_in_route, last_in_route, travel_time, demand,
		output ready_time, due_time, service_time,
		input  ready
	);
	modport sink (
		input  valid, first_in_route, last_in_route, travel_time, demand,
		input  ready_time, due_time, service_time,
		output ready
	);
endinterface

### rtl/vre_result_if.sv
// ----------------------------------------------------------------------------
// vre_result_if
// Result channel: one route score per transfer.
// ----------------------------------------------------------------------------
interface vre_result_if import vre_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACC_W-1:0]  drive_distance;
	logic [LOAD_W-1:0] total_load;
	logic [LOAD_W-1:0] capacity_excess;
	logic [ACC_W-1:0]  time_used;
	logic [ACC_W-1:0]  duration_excess;
	logic [ACC_W-1:0]  window_excess;
	logic [OBJ_W-1:0]  objective;

	modport source (
		output valid, drive_distance, total_load, capacity_excess, time_used,
		output duration_excess, window_excess, objective,
		input  ready
	);
	modport sink (
		input  valid, drive_distance, total_load, capacity_excess, time_used,
		input  duration_excess, window_excess, objective,
		output ready
	);
endinterface

### rtl/vrptw_route_evaluator_core.sv
// ----------------------------------------------------------------------------
// vrptw_route_evaluator_core
// Scores a time-windowed vehicle route streamed one visit per transfer.
// ----------------------------------------------------------------------------
// Visits are taken at one per clock unless the full scoring pipeline stalls
// them: the load, distance, completion-time and lateness sums are updated on
// each accepted visit, and that loop (arrival, max with ready time, plus
// service) sets the rate. A visit marked last also enters a four-register
// scoring pipeline (snapshot, excess, weighted products, objective) that
// holds up to four pending results, so visits keep flowing while the result
// channel stalls, until all four are full. Registers sit on APB byte addresses
// 0x0 (vehicle capacity), 0x4, 0x8, 0xC (capacity, duration, window weights).
// ----------------------------------------------------------------------------
module vrptw_route_evaluator_core import vre_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	vre_visit_if.sink         visit,
	vre_result_if.source      result
);

	cfg_t        cfg_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;
	logic        accept;
	logic        score_ready;
	totals_t     tot_next;
	route_snap_t snap;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vehicle_capacity <= CAPACITY_RESET;
			cfg_q.capacity_weight  <= WEIGHT_RESET;
			cfg_q.duration_weight  <= WEIGHT_RESET;
			cfg_q.window_weight    <= WEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_VEHICLE_CAPACITY: cfg_q.vehicle_capacity <= pwdata[CFG_W-1:0];
				REG_CAPACITY_WEIGHT:  cfg_q.capacity_weight  <= pwdata[CFG_W-1:0];
				REG_DURATION_WEIGHT:  cfg_q.duration_weight  <= pwdata[CFG_W-1:0];
				REG_WINDOW_WEIGHT:    cfg_q.window_weight    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_VEHICLE_CAPACITY: prdata = APB_DW'(cfg_q.vehicle_capacity);
			REG_CAPACITY_WEIGHT:  prdata = APB_DW'(cfg_q.capacity_weight);
			REG_DURATION_WEIGHT:  prdata = APB_DW'(cfg_q.duration_weight);
			REG_WINDOW_WEIGHT:    prdata = APB_DW'(cfg_q.window_weight);
			default:              prdata = '0;
		endcase
	end

	assign visit.ready = score_ready;
	assign accept      = visit.valid && visit.ready;

	vre_route_acc u_acc (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.first_in_route (visit.first_in_route),
		.travel_time    (visit.travel_time),
		.demand         (visit.demand),
		.ready_time     (visit.ready_time),
		.due_time       (visit.due_time),
		.service_time   (visit.service_time),
		.tot_next       (tot_next)
	);

	assign snap.tot = tot_next;
	assign snap.due = visit.due_time;

	vre_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (accept && visit.last_in_route),
		.snap   (snap),
		.ready  (score_ready),
		.result (result)
	);

endmodule

### rtl/vre_route_acc.sv
// ----------------------------------------------------------------------------
// vre_route_acc
// Per-visit accumulators: load, distance, completion time and lateness.
// ----------------------------------------------------------------------------
module vre_route_acc import vre_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                first_in_route,
	input  logic [TIME_W-1:0]   travel_time,
	input  logic [DEMAND_W-1:0] demand,
	input  logic [TIME_W-1:0]   ready_time,
	input  logic [TIME_W-1:0]   due_time,
	input  logic [TIME_W-1:0]   service_time,
	output totals_t             tot_next
);

	totals_t          tot_q;
	logic [ACC_W:0]   dist_sum;
	logic [LOAD_W:0]  load_sum;
	logic [ACC_W:0]   arr_sum;
	logic [ACC_W-1:0] arrival;
	logic [ACC_W-1:0] start_t;
	logic [ACC_W-1:0] late_diff;
	logic [ACC_W:0]   late_sum;
	logic [ACC_W:0]   comp_sum;
	logic             is_late;

	always_comb begin
		dist_sum  = {1'b0, tot_q.distance} + (ACC_W+1)'(travel_time);
		load_sum  = {1'b0, tot_q.load} + (LOAD_W+1)'(demand);
		arr_sum   = {1'b0, tot_q.completion} + (ACC_W+1)'(travel_time);
		arrival   = arr_sum[ACC_W] ? '1 : arr_sum[ACC_W-1:0];
		start_t   = (arrival < ACC_W'(ready_time)) ? ACC_W'(ready_time) : arrival;
		is_late   = arrival > ACC_W'(due_time);
		late_diff = arrival - ACC_W'(due_time);
		late_sum  = {1'b0, tot_q.lateness} + {1'b0, late_diff};
		comp_sum  = {1'b0, start_t} + (ACC_W+1)'(service_time);

		if (first_in_route) begin
			tot_next.distance   = '0;
			tot_next.load       = LOAD_W'(demand);
			tot_next.completion = '0;
			tot_next.lateness   = '0;
		end else begin
			tot_next.distance   = dist_sum[ACC_W] ? '1 : dist_sum[ACC_W-1:0];
			tot_next.load       = load_sum[LOAD_W] ? '1 : load_sum[LOAD_W-1:0];
			tot_next.completion = comp_sum[ACC_W] ? '1 : comp_sum[ACC_W-1:0];
			if (is_late) begin
				tot_next.lateness = late_sum[ACC_W] ? '1 : late_sum[ACC_W-1:0];
			end else begin
				tot_next.lateness = tot_q.lateness;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else if (accept) begin
			tot_q <= tot_next;
		end
	end

	// start depot clears the time and distance sums
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && first_in_route |=>
			tot_q.distance == '0 && tot_q.completion == '0 && tot_q.lateness == '0)
		else $error("start depot did not clear accumulators");

	// service never starts before the ready time
	a_after_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !first_in_route |=> tot_q.completion >= ACC_W'($past(ready_time)))
		else $error("completion earlier than ready time");

	// load only grows within a route
	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !first_in_route |=> tot_q.load >= $past(tot_q.load))
		else $error("load decreased within route");

endmodule

### rtl/vre_score.sv
// ----------------------------------------------------------------------------
// vre_score
// Route scoring pipeline: excesses, weighted penalties and objective.
// ----------------------------------------------------------------------------
module vre_score import vre_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         take,
	input  route_snap_t  snap,
	output logic         ready,
	vre_result_if.source result
);

	localparam int CAP_P_W = CFG_W + LOAD_W;
	localparam int ACC_P_W = CFG_W + ACC_W;

	logic              v_s1, v_s2, v_s3, out_v_q;
	logic              adv1, adv2, adv3, adv_out;
	route_snap_t       snap_s1;
	totals_t           tot_s2, tot_s3;
	logic [LOAD_W-1:0] cap_ex_s2, cap_ex_s3;
	logic [ACC_W-1:0]  dur_ex_s2, dur_ex_s3;
	logic [CAP_P_W-1:0] cap_p_s3;
	logic [ACC_P_W-1:0] dur_p_s3;
	logic [ACC_P_W-1:0] win_p_s3;
	logic [LOAD_W-1:0] cap_ex;
	logic [ACC_W-1:0]  dur_ex;
	logic [OBJ_W-1:0]  obj;

	assign adv_out = !out_v_q || result.ready;
	assign adv3    = !v_s3 || adv_out;
	assign adv2    = !v_s2 || adv3;
	assign adv1    = !v_s1 || adv2;
	assign ready   = adv1;

	always_comb begin
		cap_ex = (snap_s1.tot.load > LOAD_W'(cfg.vehicle_capacity))
			? snap_s1.tot.load - LOAD_W'(cfg.vehicle_capacity) : '0;
		dur_ex = (snap_s1.tot.completion > ACC_W'(snap_s1.due))
			? snap_s1.tot.completion - ACC_W'(snap_s1.due) : '0;
		// terms stay below 2^42, so the 48-bit sum cannot overflow
		obj = OBJ_W'(tot_s3.distance) + OBJ_W'(cap_p_s3)
			+ OBJ_W'(dur_p_s3[ACC_P_W-1:8]) + OBJ_W'(win_p_s3[ACC_P_W-1:8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= take;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				out_v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && take) begin
			snap_s1 <= snap;
		end
		if (adv2 && v_s1) begin
			tot_s2    <= snap_s1.tot;
			cap_ex_s2 <= cap_ex;
			dur_ex_s2 <= dur_ex;
		end
		if (adv3 && v_s2) begin
			tot_s3    <= tot_s2;
			cap_ex_s3 <= cap_ex_s2;
			dur_ex_s3 <= dur_ex_s2;
			cap_p_s3  <= CAP_P_W'(cfg.capacity_weight) * CAP_P_W'(cap_ex_s2);
			dur_p_s3  <= ACC_P_W'(cfg.duration_weight) * ACC_P_W'(dur_ex_s2);
			win_p_s3  <= ACC_P_W'(cfg.window_weight) * ACC_P_W'(tot_s2.lateness);
		end
		if (adv_out && v_s3) begin
			result.drive_distance  <= tot_s3.distance;
			result.total_load      <= tot_s3.load;
			result.capacity_excess <= cap_ex_s3;
			result.time_used       <= tot_s3.completion;
			result.duration_excess <= dur_ex_s3;
			result.window_excess   <= tot_s3.lateness;
			result.objective       <= obj;
		end
	end

	assign result.valid = out_v_q;

	// objective always includes the full distance
	a_obj_covers_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.objective >= OBJ_W'(result.drive_distance))
		else $error("objective below drive distance");

	// capacity excess is exactly the load over the limit
	a_cap_excess: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.capacity_excess != '0 |->
			result.total_load == result.capacity_excess + LOAD_W'(cfg.vehicle_capacity))
		else $error("capacity excess inconsistent with load");

	// input side stalls only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> v_s1 && v_s2 && v_s3 && out_v_q)
		else $error("stall with a free stage");

endmodule
